@@ src/sms_pkg.sv @@
`default_nettype none
package sms_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int MAX_RESULTS  = 32;
  localparam int COUNT_W      = 6;
  localparam int VALUE_W      = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_DRAIN  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_SHIFT  = 2'd3
  } cell_op_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] out_value;
    logic                      out_valid;
    logic                      last;
  } out_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e                  op;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

@@ src/sms_cell.sv @@
`default_nettype none
module sms_cell
  import sms_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire cell_cmd_t                 cmd_i,
  input  wire logic                      valid_i,
  input  wire logic signed [VALUE_W-1:0] left_value_i,
  input  wire logic                      left_keep_i,
  input  wire logic signed [VALUE_W-1:0] right_value_i,
  output logic signed [VALUE_W-1:0]      value_o,
  output logic                           keep_o,
  output logic                           ge_o,
  output logic                           match_o
);

  logic signed [VALUE_W-1:0] value_q, value_d;

  assign value_o = value_q;
  assign keep_o  = valid_i && (value_q <= cmd_i.value);
  assign ge_o    = valid_i && (value_q >= cmd_i.value);
  assign match_o = valid_i && (value_q == cmd_i.value);

  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      OP_INSERT: begin
        // cells at or below the new value stay; the first one above takes it
        if (!keep_o) begin
          value_d = left_keep_i ? cmd_i.value : left_value_i;
        end
      end
      OP_DELETE: begin
        if (ge_o) begin
          value_d = right_value_i;
        end
      end
      OP_SHIFT: value_d = right_value_i;
      default:  value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule
`default_nettype wire

@@ src/sorted_multiset_store.sv @@
// Channel | Dir | Handshake                 | Payload
// in      | in  | in_valid_i / in_stall_o   | in_i: kind, value
// out     | out | out_valid_o / out_stall_i | out_o: status, count, out_value, out_valid, last
//
// Insert, delete and the no-op code register their result on acceptance: every cell compares
// against the broadcast value in parallel and shifts by one neighbor in that same edge.
// A drain is accepted, then shifts the chain left one cell per cycle while the output
// is not stalled, emitting the last copy of each run; a new item waits until it ends.
// An empty drain registers its single result, marked last, on acceptance.
// Reset clears the occupancy and the control state; cell contents are not reset.
// A stalled output register stops the chain and holds off the input side.
`default_nettype none
module sorted_multiset_store
  import sms_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_o
);

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int N_W   = $clog2(MAX_RESULTS);

  state_e             state_q, state_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [N_W-1:0]     n_q, n_d;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;
  cell_cmd_t          cmd;

  logic signed [VALUE_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]       cell_valid, keep, ge, match;

  logic slot_free, accept, full, found;
  logic head_last, run_end, drain_fin, drain_step;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && slot_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (occ_q == OCC_W'(CAPACITY));
  assign found      = |match;

  assign drain_step = (state_q == ST_DRAIN) && slot_free;
  assign head_last  = (occ_q == OCC_W'(1));
  assign run_end    = head_last || (cell_value[1] != cell_value[0]);
  assign drain_fin  = head_last || (run_end && (n_q == N_W'(MAX_RESULTS - 1)));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_value, right_value;
    logic                      left_keep;

    assign cell_valid[i] = (occ_q > OCC_W'(i));

    if (i == 0) begin : g_head
      assign left_value = cmd.value;
      assign left_keep  = 1'b1;
    end else begin : g_mid
      assign left_value = cell_value[i-1];
      assign left_keep  = keep[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    sms_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .valid_i       (cell_valid[i]),
      .left_value_i  (left_value),
      .left_keep_i   (left_keep),
      .right_value_i (right_value),
      .value_o       (cell_value[i]),
      .keep_o        (keep[i]),
      .ge_o          (ge[i]),
      .match_o       (match[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.kind == KIND_DRAIN) && (occ_q != '0)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_step && drain_fin) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    cmd.op      = OP_HOLD;
    cmd.value   = in_i.value;
    occ_d       = occ_q;
    n_d         = n_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d.status    = STATUS_DONE;
          out_d.out_value = '0;
          out_d.out_valid = 1'b0;
          out_d.last      = 1'b1;
          out_valid_d     = 1'b1;
          case (in_i.kind)
            KIND_INSERT: begin
              if (full) begin
                out_d.status = STATUS_FULL;
              end else begin
                cmd.op = OP_INSERT;
                occ_d  = occ_q + OCC_W'(1);
              end
            end
            KIND_DELETE: begin
              if (found) begin
                cmd.op = OP_DELETE;
                occ_d  = occ_q - OCC_W'(1);
              end else begin
                out_d.status = STATUS_NOT_FOUND;
              end
            end
            KIND_DRAIN: begin
              n_d = '0;
              if (occ_q != '0) begin
                out_valid_d = out_valid_q && out_stall_i;
              end
            end
            default: ;
          endcase
          out_d.count = COUNT_W'(occ_d);
        end
      end
      ST_DRAIN: begin
        if (drain_step) begin
          cmd.op = OP_SHIFT;
          occ_d  = drain_fin ? '0 : occ_q - OCC_W'(1);
          if (run_end) begin
            out_d.status    = STATUS_DONE;
            out_d.count     = '0;
            out_d.out_value = cell_value[0];
            out_d.out_valid = 1'b1;
            out_d.last      = drain_fin;
            out_valid_d     = 1'b1;
            n_d             = n_q + N_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

@@ src/sms_checker.sv @@
`default_nettype none
module sms_checker
  import sms_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_o
);

  // a stalled item holds and keeps the input side off
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o ##1 (out_valid_o && $stable(out_o)))
    else $error("output item changed while stalled");

  // only drained values can be non-final
  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.out_valid |-> out_o.last && (out_o.out_value == '0))
    else $error("non-drain result not marked last");

  // drained values carry an empty count and done status
  a_drain_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.out_valid |-> (out_o.count == '0) &&
      (out_o.status == STATUS_DONE))
    else $error("drain result with bad status or count");

  // drained values come out strictly ascending within one drain
  a_drain_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_o.out_valid && !out_o.last ##1
      out_valid_o && out_o.out_valid |-> out_o.out_value > $past(out_o.out_value))
    else $error("drain values not ascending");

  // a full rejection reports a count equal to the capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == STATUS_FULL) |->
      (out_o.count == COUNT_W'(CAPACITY)))
    else $error("full rejection with wrong count");

endmodule

bind sorted_multiset_store sms_checker #(.CAPACITY(CAPACITY)) u_sms_checker (.*);
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
  import sms_pkg::*;

  localparam int STORE_DEPTH = CAPACITY_DEF;
  localparam int ITEM_TARGET = 300;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 1500;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  sorted_multiset_store dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the sorted store plus the results it still owes.
  class multiset_tracker;
    logic signed [VALUE_W-1:0] shadow_cells [STORE_DEPTH];
    int unsigned shadow_count;
    out_t pending_results [$];
    int unsigned errors, compared, inputs, drains, full_rejects, misses, widest_drain;

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function logic signed [VALUE_W-1:0] any_member();
      return shadow_cells[$urandom_range(0, shadow_count - 1)];
    endfunction

    function void owe_result(status_e status, int unsigned cnt,
                             logic signed [VALUE_W-1:0] value, bit valid, bit fin);
      out_t r;
      r.status    = status;
      r.count     = cnt[COUNT_W-1:0];
      r.out_value = value;
      r.out_valid = valid;
      r.last      = fin;
      pending_results.push_back(r);
    endfunction

    function void note_input(in_t item);
      logic signed [VALUE_W-1:0] v;
      int unsigned pos, i, emitted;
      out_t tail;
      v = item.value;
      inputs++;
      case (item.kind)
        KIND_INSERT: begin
          if (shadow_count >= STORE_DEPTH) begin
            full_rejects++;
            owe_result(STATUS_FULL, shadow_count, '0, 1'b0, 1'b1);
          end else begin
            // equal copies stay ahead of the new one
            pos = 0;
            while (pos < shadow_count && shadow_cells[pos] <= v) pos++;
            for (i = shadow_count; i > pos; i--) shadow_cells[i] = shadow_cells[i - 1];
            shadow_cells[pos] = v;
            shadow_count++;
            owe_result(STATUS_DONE, shadow_count, '0, 1'b0, 1'b1);
          end
        end
        KIND_DELETE: begin
          pos = 0;
          while (pos < shadow_count && shadow_cells[pos] != v) pos++;
          if (pos == shadow_count) begin
            misses++;
            owe_result(STATUS_NOT_FOUND, shadow_count, '0, 1'b0, 1'b1);
          end else begin
            for (i = pos; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i + 1];
            shadow_count--;
            owe_result(STATUS_DONE, shadow_count, '0, 1'b0, 1'b1);
          end
        end
        KIND_DRAIN: begin
          drains++;
          if (shadow_count == 0) begin
            owe_result(STATUS_DONE, 0, '0, 1'b0, 1'b1);
          end else begin
            emitted = 0;
            for (i = 0; i < shadow_count && emitted < MAX_RESULTS; i++) begin
              if (i == 0 || shadow_cells[i] != shadow_cells[i - 1]) begin
                owe_result(STATUS_DONE, 0, shadow_cells[i], 1'b1, 1'b0);
                emitted++;
              end
            end
            tail = pending_results.pop_back();
            tail.last = 1'b1;
            pending_results.push_back(tail);
            if (emitted > widest_drain) widest_drain = emitted;
            shadow_count = 0;
          end
        end
        default: begin
          owe_result(STATUS_DONE, shadow_count, '0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $error("result with nothing pending: %p", got);
        return;
      end
      want = pending_results.pop_front();
      compared++;
      check_field("status", want.status, got.status);
      check_field("count", want.count, got.count);
      check_field("out_value", want.out_value, got.out_value);
      check_field("out_valid", want.out_valid, got.out_valid);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  multiset_tracker tracker;
  bit sender_eager;
  bit receiver_eager;
  bit offering;
  int hold_request;
  int items_sent;
  int pauses;
  int quiet_cycles;

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3: return $urandom;
      default: return int'($urandom_range(0, 12)) - 6;
    endcase
  endfunction

  task automatic offer(input logic [1:0] kind, input logic signed [VALUE_W-1:0] value);
    in_t item;
    int gap;
    item.kind  = kind;
    item.value = value;
    gap = sender_eager ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      if (offering) in_valid_i <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_input(item);
    items_sent++;
  endtask

  // sender goes quiet until the store has delivered everything it owes
  task automatic wait_until_settled();
    if (offering) in_valid_i <= 1'b0;
    offering = 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  task automatic churn(input int n);
    int k, roll;
    logic [1:0] kind;
    logic signed [VALUE_W-1:0] v;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) kind = KIND_INSERT;
      else if (roll < 85) kind = KIND_DELETE;
      else if (roll < 95) kind = KIND_DRAIN;
      else kind = KIND_UNUSED;
      v = pick_value();
      if (kind == KIND_DELETE && tracker.shadow_count > 0 && $urandom_range(0, 2) != 0)
        v = tracker.any_member();
      offer(kind, v);
    end
  endtask

  // empty the store, overfill, free one slot, refill, then drain a full store
  task automatic fill_and_drain(input bit with_copies);
    int k;
    offer(KIND_DRAIN, $urandom);
    for (k = 0; k < STORE_DEPTH + 2; k++)
      offer(KIND_INSERT, with_copies ? pick_value() : $urandom);
    offer(KIND_DELETE, tracker.any_member());
    offer(KIND_INSERT, $urandom);
    offer(KIND_INSERT, $urandom);
    offer(KIND_DRAIN, $urandom);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no item moved for %0d cycles", quiet_cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : result_sink
    int hold;
    @(posedge rst_ni);
    forever begin
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end else begin
        hold = receiver_eager ? 0 : $urandom_range(0, 14);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      tracker.check_result(out_o);
    end
  end

  initial begin : stimulus
    int phase;
    tracker = new;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners: empty store, unused code, extremes, duplicates, misses
    offer(KIND_DRAIN, $urandom);
    offer(KIND_UNUSED, '0);
    offer(KIND_DELETE, '0);
    offer(KIND_INSERT, VAL_MAX);
    offer(KIND_INSERT, VAL_MIN);
    offer(KIND_INSERT, '0);
    offer(KIND_INSERT, -1);
    offer(KIND_INSERT, 1);
    offer(KIND_INSERT, VAL_MAX);
    offer(KIND_INSERT, VAL_MIN);
    offer(KIND_INSERT, 1);
    offer(KIND_UNUSED, VAL_MIN);
    offer(KIND_DELETE, VAL_MAX);
    offer(KIND_DELETE, 7);
    offer(KIND_DELETE, VAL_MIN);
    offer(KIND_DELETE, -1);
    offer(KIND_DRAIN, VAL_MAX);
    offer(KIND_DRAIN, '0);
    wait_until_settled();
    pauses++;

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      sender_eager   = ($urandom_range(0, 3) == 0);
      receiver_eager = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // back up the output so the input side has to stall
        sender_eager = 1'b1;
        hold_request = LONG_HOLD;
      end
      if (phase % 4 == 0) fill_and_drain(phase % 8 == 4);
      else churn($urandom_range(15, 35));
      if (phase == 1 || $urandom_range(0, 3) == 0) begin
        wait_until_settled();
        pauses++;
      end
      phase++;
    end

    wait_until_settled();
    repeat (2 * STORE_DEPTH + 8) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      tracker.errors++;
      $error("%0d results never arrived", tracker.pending());
    end

    $display("run: %0d items in, %0d results compared, %0d drains (widest %0d values)",
             tracker.inputs, tracker.compared, tracker.drains, tracker.widest_drain);
    $display("run: %0d full-store rejects, %0d delete misses, %0d sender pauses, one long hold",
             tracker.full_rejects, tracker.misses, pauses);
    if (tracker.errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end
endmodule
